// ===== design/ihc_pkg.sv =====
// ----------------------------------------------------------------------------
// ihc_pkg
// Shared types and constants for the IPv4 header parser and checksum checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ihc_pkg;

	// Header geometry and field constants.
	localparam int unsigned HDR_BYTES    = 20;
	localparam int unsigned COUNT_W      = 16;
	localparam int unsigned SUM_W        = 21;
	localparam int unsigned HSIZE_W      = 6;
	localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;
	localparam logic [COUNT_W-1:0] HDR_MIN_COUNT = 16'd20;
	localparam logic [3:0]  IPV4_VERSION = 4'd4;
	localparam logic [3:0]  MIN_IHL      = 4'd5;
	localparam logic [15:0] SUM_ALL_ONES = 16'hFFFF;

	// Result status codes, in check order.
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_VERSION   = 3'd2,
		ST_IHL       = 3'd3,
		ST_UNDER_IHL = 3'd4,
		ST_LEN_SMALL = 3'd5,
		ST_LEN_BIG   = 3'd6,
		ST_CHECKSUM  = 3'd7
	} status_t;

	// One input request: a buffer byte and its last-byte marker.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_req_t;

	// One result request: status plus decoded header fields.
	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  vers_hlen;
		logic [7:0]  tos_byte;
		logic [15:0] pkt_len;
		logic [15:0] identification;
		logic [15:0] flags_fragment;
		logic [7:0]  time_to_live;
		logic [7:0]  upper_protocol;
		logic [15:0] stored_checksum;
		logic [31:0] source_address;
		logic [31:0] dest_address;
	} result_t;

	// Snapshot of one finished buffer, handed from front to back.
	typedef struct packed {
		logic [HDR_BYTES-1:0][7:0] hdr;
		logic [COUNT_W-1:0]        count;
		logic [SUM_W-1:0]          sum;
	} hdr_rec_t;

	// Write side of the record queue.
	typedef struct packed {
		logic     push;
		hdr_rec_t rec;
	} q_push_t;

	// Status of the record queue.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

// ===== design/ihc_front.sv =====
// ----------------------------------------------------------------------------
// ihc_front
// Byte intake: counts bytes, captures the first 20 header bytes and keeps
// the running header word sum; pushes a record on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ihc_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               byte_valid,
	output logic                    byte_ready,
	input  wire ihc_pkg::byte_req_t byte_data,
	input  wire ihc_pkg::q_stat_t   q_stat,
	output ihc_pkg::q_push_t        q_wr
);

	logic [ihc_pkg::COUNT_W-1:0]                count_q;
	logic [ihc_pkg::SUM_W-1:0]                  sum_q;
	logic [7:0]                                 pend_q;
	logic [ihc_pkg::HDR_BYTES-1:0][7:0]         hdr_q;

	logic                                       accept;
	logic [ihc_pkg::HDR_BYTES-1:0][7:0]         hdr_n;
	logic [ihc_pkg::COUNT_W-1:0]                count_n;
	logic [ihc_pkg::SUM_W-1:0]                  sum_n;
	logic [ihc_pkg::COUNT_W-1:0]                hsize;
	logic                                       in_hdr_word;

	// A new byte is taken whenever the queue has room for a finished buffer.
	assign byte_ready = !q_stat.full;
	assign accept     = byte_valid && byte_ready;

	// Merge the incoming byte into the header bytes at its position.
	always_comb begin
		hdr_n = hdr_q;
		for (int i = 0; i < ihc_pkg::HDR_BYTES; i++) begin
			if (count_q == ihc_pkg::COUNT_W'(i)) begin
				hdr_n[i] = byte_data.data_byte;
			end
		end
	end

	// Saturating byte count.
	assign count_n = (count_q == ihc_pkg::COUNT_MAX) ? count_q
		: count_q + ihc_pkg::COUNT_W'(1);

	// Declared header size in bytes, from the IHL nibble already stored.
	assign hsize = {{(ihc_pkg::COUNT_W - ihc_pkg::HSIZE_W){1'b0}}, hdr_q[0][3:0], 2'b00};

	// An odd byte completes a word; it counts when it lies inside the header.
	assign in_hdr_word = count_q[0] && (count_q < hsize);
	assign sum_n = in_hdr_word
		? sum_q + ihc_pkg::SUM_W'({pend_q, byte_data.data_byte})
		: sum_q;

	// Record for the back end, built from this cycle's updated state.
	always_comb begin
		q_wr.push      = accept && byte_data.last_byte;
		q_wr.rec.hdr   = hdr_n;
		q_wr.rec.count = count_n;
		q_wr.rec.sum   = sum_n;
	end

	// Running state; cleared at the end of every buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			pend_q  <= '0;
		end else if (accept) begin
			if (byte_data.last_byte) begin
				count_q <= '0;
				sum_q   <= '0;
				pend_q  <= '0;
			end else begin
				count_q <= count_n;
				sum_q   <= sum_n;
				if (!count_q[0]) begin
					pend_q <= byte_data.data_byte;
				end
			end
		end
	end

	// Header byte capture; only the first 20 positions ever change.
	always_ff @(posedge clk) begin
		if (accept) begin
			hdr_q <= hdr_n;
		end
	end

endmodule

`default_nettype wire

// ===== design/ihc_queue.sv =====
// ----------------------------------------------------------------------------
// ihc_queue
// Small FIFO of finished-buffer records between intake and result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ihc_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ihc_pkg::q_push_t  q_wr,
	input  wire logic              pop,
	output ihc_pkg::q_stat_t       q_stat,
	output ihc_pkg::hdr_rec_t      head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	ihc_pkg::hdr_rec_t   mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                do_push;
	logic                do_pop;

	assign q_stat.full  = (cnt_q == CNT_FULL);
	assign q_stat.empty = (cnt_q == '0);
	assign do_push      = q_wr.push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head         = mem_q[rd_ptr_q];

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Record storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= q_wr.rec;
		end
	end

endmodule

`default_nettype wire

// ===== design/ihc_back.sv =====
// ----------------------------------------------------------------------------
// ihc_back
// Result stage: runs the header checks on a queued record, decodes the
// fields and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ihc_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ihc_pkg::hdr_rec_t head,
	input  wire ihc_pkg::q_stat_t  q_stat,
	output logic                   pop,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output ihc_pkg::result_t       result
);

	logic                          out_valid_q;
	ihc_pkg::result_t              out_q;
	ihc_pkg::result_t              res_n;
	ihc_pkg::status_t              status;
	logic [3:0]                    ihl;
	logic [ihc_pkg::COUNT_W-1:0]   hsize;
	logic [15:0]                   tl;
	logic [16:0]                   fold1;
	logic [15:0]                   fold2;

	assign ihl   = head.hdr[0][3:0];
	assign hsize = {{(ihc_pkg::COUNT_W - ihc_pkg::HSIZE_W){1'b0}}, ihl, 2'b00};
	assign tl    = {head.hdr[2], head.hdr[3]};

	// Ones' complement fold of the word sum with end-around carry.
	assign fold1 = {1'b0, head.sum[15:0]} + {12'b0, head.sum[ihc_pkg::SUM_W-1:16]};
	assign fold2 = fold1[15:0] + {15'b0, fold1[16]};

	// Checks in priority order; the first failure sets the status.
	always_comb begin
		priority if (head.count < ihc_pkg::HDR_MIN_COUNT) begin
			status = ihc_pkg::ST_SHORT;
		end else if (head.hdr[0][7:4] != ihc_pkg::IPV4_VERSION) begin
			status = ihc_pkg::ST_VERSION;
		end else if (ihl < ihc_pkg::MIN_IHL) begin
			status = ihc_pkg::ST_IHL;
		end else if (head.count < hsize) begin
			status = ihc_pkg::ST_UNDER_IHL;
		end else if (tl < hsize) begin
			status = ihc_pkg::ST_LEN_SMALL;
		end else if (tl > head.count) begin
			status = ihc_pkg::ST_LEN_BIG;
		end else if (fold2 != ihc_pkg::SUM_ALL_ONES) begin
			status = ihc_pkg::ST_CHECKSUM;
		end else begin
			status = ihc_pkg::ST_OK;
		end
	end

	// Decoded fields, forced to zero unless the header passed.
	always_comb begin
		res_n = '0;
		res_n.status = status;
		if (status == ihc_pkg::ST_OK) begin
			res_n.vers_hlen       = head.hdr[0];
			res_n.tos_byte        = head.hdr[1];
			res_n.pkt_len         = tl;
			res_n.identification  = {head.hdr[4], head.hdr[5]};
			res_n.flags_fragment  = {head.hdr[6], head.hdr[7]};
			res_n.time_to_live    = head.hdr[8];
			res_n.upper_protocol  = head.hdr[9];
			res_n.stored_checksum = {head.hdr[10], head.hdr[11]};
			res_n.source_address  = {head.hdr[12], head.hdr[13], head.hdr[14], head.hdr[15]};
			res_n.dest_address    = {head.hdr[16], head.hdr[17], head.hdr[18], head.hdr[19]};
		end
	end

	// Take the next record when the output register is empty or draining.
	assign pop = !q_stat.empty && (!out_valid_q || result_ready);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res_n;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

// ===== design/ipv4_header_check_parse.sv =====
// ----------------------------------------------------------------------------
// ipv4_header_check_parse
// IPv4 header parser with header checksum verification, one byte per cycle while the record queue has room.
// ----------------------------------------------------------------------------
// Usage:
//   The byte channel (byte_valid/byte_ready/byte_data) carries one buffer
//   byte per request, with last_byte set on the final byte of the buffer.
//   The result channel (result_valid/result_ready/result) carries one
//   request per buffer: a status code and the decoded header fields, which
//   are zero unless the status is ok.
//   Throughput is one byte per cycle while the record queue is not full,
//   including buffers that follow each other directly and buffers of a
//   single byte; the intake updates its count and word sum for every byte.
//   After the last byte is taken, its record is written to the record queue
//   and then to the output register; the check and decode run in the result
//   stage from the record queue head straight into the output register.
//   When the receiver stalls, finished buffers collect in the record queue
//   (QUEUE_DEPTH entries) while bytes keep flowing; byte_ready drops only
//   once the queue is full.
//   Reset clears the byte count, word sum, queue and output valid flag; no
//   result is pending afterward and the next byte starts a new buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_header_check_parse #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               byte_valid,
	output logic                    byte_ready,
	input  wire ihc_pkg::byte_req_t byte_data,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output ihc_pkg::result_t        result
);

	ihc_pkg::q_push_t  q_wr;
	ihc_pkg::q_stat_t  q_stat;
	ihc_pkg::hdr_rec_t head;
	logic              pop;

	// Byte intake and running header state.
	ihc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.q_stat     (q_stat),
		.q_wr       (q_wr)
	);

	// Record queue between intake and result stage.
	ihc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.pop    (pop),
		.q_stat (q_stat),
		.head   (head)
	);

	// Checks, decode and output register.
	ihc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_stat       (q_stat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire

// ===== design/ihc_checker.sv =====
// ----------------------------------------------------------------------------
// ihc_checker
// Port-level checks for the IPv4 header parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ihc_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               byte_valid,
	input wire logic               byte_ready,
	input wire ihc_pkg::byte_req_t byte_data,
	input wire logic               result_valid,
	input wire logic               result_ready,
	input wire ihc_pkg::result_t   result
);

	// A stalled byte request keeps its payload until it is taken.
	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_ready |=> byte_valid && $stable(byte_data))
		else $error("byte request changed or dropped while stalled");

	// A stalled result request holds its payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed or dropped while stalled");

	// A failed header reports no decoded fields.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status != ihc_pkg::ST_OK) |->
			(result.vers_hlen == '0) && (result.pkt_len == '0) &&
			(result.source_address == '0) && (result.dest_address == '0) &&
			(result.stored_checksum == '0))
		else $error("fields not cleared on failed header");

	// A passing header has version 4, a legal IHL and a consistent length.
	a_ok_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ihc_pkg::ST_OK) |->
			(result.vers_hlen[7:4] == ihc_pkg::IPV4_VERSION) &&
			(result.vers_hlen[3:0] >= ihc_pkg::MIN_IHL) &&
			(result.pkt_len >= {10'b0, result.vers_hlen[3:0], 2'b00}))
		else $error("ok status with inconsistent header fields");

	// Intake stalls only when results are backed up at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> result_valid)
		else $error("byte intake stalled with no result pending");

endmodule

bind ipv4_header_check_parse ihc_checker u_ihc_checker (.*);

`default_nettype wire

// ===== bench/ipv4_header_check_parse_tb.sv =====
// ----------------------------------------------------------------------------
// ipv4_header_check_parse_tb
// Self-checking bench for the byte-serial IPv4 header parser and checksum
// checker. Buffers are sent a byte per request over the byte channel. A
// local header model predicts the status and decoded fields of each buffer.
// A short directed table runs first: the error codes, field extremes and
// option headers. Then come random buffers, mostly well-formed with random
// content and some broken or pure noise, under three idle patterns and one
// long result stall.
// ----------------------------------------------------------------------------

module ipv4_header_check_parse_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// How the non-structural bytes of a built buffer are filled.
	typedef enum logic [1:0] {
		FILL_RAND,
		FILL_ZERO,
		FILL_ONES
	} fill_t;

	// One directed buffer; want_status is used only when typed is set.
	typedef struct packed {
		logic [31:0]      n_bytes;
		logic [3:0]       ver;
		logic [3:0]       ihl;
		logic [15:0]      tot_len;
		fill_t            fill;
		logic             bad_csum;
		logic             typed;
		ihc_pkg::status_t want_status;
	} dir_row_t;

	localparam int unsigned N_DIR       = 17;
	localparam int unsigned PHASE_BYTES = 30;
	localparam int unsigned PHASE_BUFS  = 2;
	localparam int unsigned HOLD_BUFS   = 4;
	localparam int unsigned HOLD_CYCLES = 300;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               byte_valid   = 1'b0;
	logic               byte_ready;
	ihc_pkg::byte_req_t byte_data    = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	ihc_pkg::result_t   result;

	// Header model state.
	logic [15:0] acc_count = '0;
	logic [20:0] acc_sum   = '0;
	logic [7:0]  acc_high  = '0;
	logic [7:0]  acc_hdr [ihc_pkg::HDR_BYTES];

	ihc_pkg::result_t hdr_expect_q [$];
	logic [7:0]       frame_q [$];
	int unsigned      err_cnt       = 0;
	int unsigned      tx_idle_pct   = 0;
	int unsigned      rx_idle_pct   = 0;
	int unsigned      phase_bytes   = 0;
	int unsigned      phase_bufs    = 0;
	int unsigned      rx_hold_left  = 0;
	bit               rx_hold_req   = 1'b0;
	dir_row_t         dir_tab [N_DIR];

	ipv4_header_check_parse u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_data    (byte_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		foreach (acc_hdr[i]) acc_hdr[i] = 8'h00;
	end

	function automatic dir_row_t make_row(input int unsigned n, input int unsigned ver,
			input int unsigned ihl, input int unsigned tl, input fill_t fill,
			input bit bad, input bit typed, input ihc_pkg::status_t st);
		dir_row_t row;
		row.n_bytes     = n;
		row.ver         = 4'(ver);
		row.ihl         = 4'(ihl);
		row.tot_len     = 16'(tl);
		row.fill        = fill;
		row.bad_csum    = bad;
		row.typed       = typed;
		row.want_status = st;
		return row;
	endfunction

	// Model of the parser: takes one byte, and on the last byte of a buffer
	// returns the result and clears its state for the next buffer.
	task automatic parse_byte(input logic [7:0] b, input logic is_last,
			output bit done, output ihc_pkg::result_t res);
		logic [15:0]      hsize;
		logic [15:0]      tl;
		logic [20:0]      folded;
		ihc_pkg::status_t st;
		done = 1'b0;
		res  = '0;
		if (acc_count < ihc_pkg::HDR_MIN_COUNT) acc_hdr[acc_count] = b;
		// Even bytes start a word; odd bytes complete it inside the header.
		if (!acc_count[0]) begin
			acc_high = b;
		end else begin
			hsize = {10'b0, acc_hdr[0][3:0], 2'b00};
			if (acc_count < hsize) acc_sum = acc_sum + 21'({acc_high, b});
		end
		if (acc_count != ihc_pkg::COUNT_MAX) acc_count = acc_count + 16'd1;
		if (!is_last) return;

		hsize  = {10'b0, acc_hdr[0][3:0], 2'b00};
		tl     = {acc_hdr[2], acc_hdr[3]};
		folded = acc_sum;
		while (folded[20:16] != '0) folded = 21'(folded[15:0]) + 21'(folded[20:16]);

		// The first failing check decides the status.
		if (acc_count < ihc_pkg::HDR_MIN_COUNT) st = ihc_pkg::ST_SHORT;
		else if (acc_hdr[0][7:4] != ihc_pkg::IPV4_VERSION) st = ihc_pkg::ST_VERSION;
		else if (acc_hdr[0][3:0] < ihc_pkg::MIN_IHL) st = ihc_pkg::ST_IHL;
		else if (acc_count < hsize) st = ihc_pkg::ST_UNDER_IHL;
		else if (tl < hsize) st = ihc_pkg::ST_LEN_SMALL;
		else if (tl > acc_count) st = ihc_pkg::ST_LEN_BIG;
		else if (folded[15:0] != ihc_pkg::SUM_ALL_ONES) st = ihc_pkg::ST_CHECKSUM;
		else st = ihc_pkg::ST_OK;

		res.status = st;
		if (st == ihc_pkg::ST_OK) begin
			res.vers_hlen       = acc_hdr[0];
			res.tos_byte        = acc_hdr[1];
			res.pkt_len         = tl;
			res.identification  = {acc_hdr[4], acc_hdr[5]};
			res.flags_fragment  = {acc_hdr[6], acc_hdr[7]};
			res.time_to_live    = acc_hdr[8];
			res.upper_protocol  = acc_hdr[9];
			res.stored_checksum = {acc_hdr[10], acc_hdr[11]};
			res.source_address  = {acc_hdr[12], acc_hdr[13], acc_hdr[14], acc_hdr[15]};
			res.dest_address    = {acc_hdr[16], acc_hdr[17], acc_hdr[18], acc_hdr[19]};
		end
		acc_count = '0;
		acc_sum   = '0;
		acc_high  = '0;
		foreach (acc_hdr[i]) acc_hdr[i] = 8'h00;
		done = 1'b1;
	endtask

	// Builds a buffer in frame_q with the given version, IHL and total length,
	// and for buffers over 11 bytes a header checksum that verifies unless bad is set.
	task automatic build_frame(input int unsigned n, input logic [3:0] ver,
			input logic [3:0] ihl, input logic [15:0] tl, input fill_t fill,
			input logic bad);
		int unsigned hsize;
		int unsigned i;
		int unsigned sum;
		logic [7:0]  v;
		frame_q.delete();
		for (i = 0; i < n; i++) begin
			case (fill)
				FILL_ZERO: v = 8'h00;
				FILL_ONES: v = 8'hFF;
				default:   v = 8'($urandom);
			endcase
			frame_q.push_back(v);
		end
		if (n > 0) frame_q[0] = {ver, ihl};
		if (n > 3) begin
			frame_q[2] = tl[15:8];
			frame_q[3] = tl[7:0];
		end
		if (n > 11) begin
			frame_q[10] = 8'h00;
			frame_q[11] = 8'h00;
			hsize = 4 * int'(ihl);
			sum   = 0;
			for (i = 0; i + 1 < hsize && i + 1 < n; i += 2)
				sum += {frame_q[i], frame_q[i + 1]};
			while ((sum >> 16) != 0) sum = (sum & 32'hFFFF) + (sum >> 16);
			sum = ~sum & 32'hFFFF;
			frame_q[10] = sum[15:8];
			frame_q[11] = sum[7:0] ^ {7'd0, bad};
		end
	endtask

	// Random buffer: mostly well-formed, some with one defect, some noise.
	task automatic random_frame();
		int unsigned kind;
		int unsigned ihl;
		int unsigned hsize;
		int unsigned n;
		int unsigned i;
		logic [15:0] tl;
		logic [3:0]  ver;
		logic        bad;
		kind  = $urandom_range(99);
		ihl   = ($urandom_range(9) < 6) ? 5 : $urandom_range(15, 6);
		hsize = ihl * 4;
		n     = hsize + $urandom_range(12);
		tl    = 16'($urandom_range(n, hsize));
		ver   = ihc_pkg::IPV4_VERSION;
		bad   = 1'b0;
		if (kind < 70) begin
			build_frame(n, ver, 4'(ihl), tl, FILL_RAND, 1'b0);
		end else if (kind < 85) begin
			case ($urandom_range(5))
				0: begin
					ver = 4'($urandom_range(14));
					if (ver >= ihc_pkg::IPV4_VERSION) ver = ver + 4'd1;
				end
				1: ihl = $urandom_range(4);
				2: begin
					ihl   = $urandom_range(15, 6);
					hsize = ihl * 4;
					n     = $urandom_range(hsize - 1, 20);
					tl    = 16'(hsize);
				end
				3: tl = 16'($urandom_range(hsize - 1));
				4: tl = 16'($urandom_range(n + 40, n + 1));
				default: bad = 1'b1;
			endcase
			build_frame(n, ver, 4'(ihl), tl, FILL_RAND, bad);
		end else begin
			frame_q.delete();
			n = $urandom_range(30, 1);
			for (i = 0; i < n; i++) frame_q.push_back(8'($urandom));
		end
	endtask

	// Sends frame_q a request at a time. A typed buffer queues the given
	// error status with zero fields instead of the model's result.
	task automatic send_frame(input logic typed, input ihc_pkg::status_t want_st);
		int unsigned      i;
		int unsigned      n;
		bit               done;
		ihc_pkg::result_t res;
		n = frame_q.size();
		for (i = 0; i < n; i++) begin
			while ($urandom_range(99) < tx_idle_pct) begin
				byte_valid <= 1'b0;
				@(posedge clk);
			end
			byte_valid <= 1'b1;
			byte_data  <= '{data_byte: frame_q[i], last_byte: (i == n - 1)};
			@(posedge clk);
			while (!byte_ready) @(posedge clk);
			parse_byte(frame_q[i], i == n - 1, done, res);
			if (done) begin
				if (typed) begin
					res        = '0;
					res.status = want_st;
				end
				hdr_expect_q.push_back(res);
			end
		end
		phase_bytes += n;
		phase_bufs++;
	endtask

	// Holds the sender off until every queued result has been taken.
	task automatic drain_results();
		byte_valid <= 1'b0;
		while (hdr_expect_q.size() != 0) @(posedge clk);
	endtask

	function automatic void cmp_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			err_cnt++;
		end
	endfunction

	task automatic check_result(input ihc_pkg::result_t got);
		ihc_pkg::result_t want;
		if (hdr_expect_q.size() == 0) begin
			$error("result with none expected: status %0d", got.status);
			err_cnt++;
			return;
		end
		want = hdr_expect_q.pop_front();
		cmp_field("status", 32'(want.status), 32'(got.status));
		cmp_field("vers_hlen", 32'(want.vers_hlen), 32'(got.vers_hlen));
		cmp_field("tos_byte", 32'(want.tos_byte), 32'(got.tos_byte));
		cmp_field("pkt_len", 32'(want.pkt_len), 32'(got.pkt_len));
		cmp_field("identification", 32'(want.identification), 32'(got.identification));
		cmp_field("flags_fragment", 32'(want.flags_fragment), 32'(got.flags_fragment));
		cmp_field("time_to_live", 32'(want.time_to_live), 32'(got.time_to_live));
		cmp_field("upper_protocol", 32'(want.upper_protocol), 32'(got.upper_protocol));
		cmp_field("stored_checksum", 32'(want.stored_checksum), 32'(got.stored_checksum));
		cmp_field("source_address", want.source_address, got.source_address);
		cmp_field("dest_address", want.dest_address, got.dest_address);
	endtask

	// Result side: checks each accepted request, then picks the next ready,
	// honoring a long hold when the sender asks for one.
	initial begin
		forever begin
			@(posedge clk);
			if (result_valid && result_ready) check_result(result);
			if (rx_hold_req) begin
				rx_hold_left = HOLD_CYCLES;
				rx_hold_req  = 1'b0;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Main sequence: reset, directed table, then three random phases.
	initial begin
		int unsigned r;
		int unsigned phase;
		dir_row_t    row;

		dir_tab[0]  = make_row(1, 4, 5, 20, FILL_ZERO, 1'b0, 1'b1, ihc_pkg::ST_SHORT);
		dir_tab[1]  = make_row(19, 4, 5, 19, FILL_ONES, 1'b0, 1'b1, ihc_pkg::ST_SHORT);
		dir_tab[2]  = make_row(20, 6, 5, 20, FILL_RAND, 1'b0, 1'b1, ihc_pkg::ST_VERSION);
		dir_tab[3]  = make_row(20, 0, 5, 20, FILL_ZERO, 1'b0, 1'b1, ihc_pkg::ST_VERSION);
		dir_tab[4]  = make_row(20, 15, 15, 20, FILL_ONES, 1'b0, 1'b1, ihc_pkg::ST_VERSION);
		dir_tab[5]  = make_row(20, 4, 4, 20, FILL_RAND, 1'b0, 1'b1, ihc_pkg::ST_IHL);
		dir_tab[6]  = make_row(20, 4, 0, 20, FILL_ZERO, 1'b0, 1'b1, ihc_pkg::ST_IHL);
		dir_tab[7]  = make_row(20, 4, 15, 60, FILL_RAND, 1'b0, 1'b1, ihc_pkg::ST_UNDER_IHL);
		dir_tab[8]  = make_row(20, 4, 5, 0, FILL_RAND, 1'b0, 1'b1, ihc_pkg::ST_LEN_SMALL);
		dir_tab[9]  = make_row(40, 4, 10, 39, FILL_RAND, 1'b0, 1'b1, ihc_pkg::ST_LEN_SMALL);
		dir_tab[10] = make_row(24, 4, 5, 25, FILL_RAND, 1'b0, 1'b1, ihc_pkg::ST_LEN_BIG);
		dir_tab[11] = make_row(20, 4, 5, 65535, FILL_ONES, 1'b0, 1'b1, ihc_pkg::ST_LEN_BIG);
		dir_tab[12] = make_row(20, 4, 5, 20, FILL_RAND, 1'b1, 1'b1, ihc_pkg::ST_CHECKSUM);
		dir_tab[13] = make_row(20, 4, 5, 20, FILL_ZERO, 1'b0, 1'b0, ihc_pkg::ST_OK);
		dir_tab[14] = make_row(20, 4, 5, 20, FILL_ONES, 1'b0, 1'b0, ihc_pkg::ST_OK);
		dir_tab[15] = make_row(60, 4, 15, 60, FILL_RAND, 1'b0, 1'b0, ihc_pkg::ST_OK);
		dir_tab[16] = make_row(33, 4, 6, 27, FILL_RAND, 1'b0, 1'b0, ihc_pkg::ST_OK);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 21;
		rx_idle_pct = 85;
		for (r = 0; r < N_DIR; r++) begin
			row = dir_tab[r];
			build_frame(row.n_bytes, row.ver, row.ihl, row.tot_len, row.fill, row.bad_csum);
			send_frame(row.typed, row.want_status);
		end

		for (phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				drain_results();
				tx_idle_pct = 85;
				rx_idle_pct = 21;
			end else if (phase == 2) begin
				drain_results();
				tx_idle_pct = 0;
				rx_idle_pct = 0;
				// Long result stall while bytes keep coming, so the record
				// queue fills and the byte channel backs up.
				rx_hold_req = 1'b1;
			end
			phase_bytes = 0;
			phase_bufs  = 0;
			while (phase_bytes < PHASE_BYTES ||
					phase_bufs < ((phase == 2) ? HOLD_BUFS : PHASE_BUFS)) begin
				random_frame();
				send_frame(1'b0, ihc_pkg::ST_OK);
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog: a limit far beyond the slowest legal run, even with every
	// buffer a single byte under idling.
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
